FILE: src/tmwf_pkg.sv
// Shared constants and types for the trimmed mean window filter.
`default_nettype none
package tmwf_pkg;

	localparam int SAMPLE_W = 16;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

FILE: src/tmwf_div.sv
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module tmwf_div #(
	parameter int DIVIDEND_W = 20,
	parameter int DIVISOR_W = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic signed [DIVIDEND_W-1:0] dividend,
	input  wire logic        [DIVISOR_W-1:0]  divisor,
	output logic signed      [DIVIDEND_W-1:0] quotient,
	output tmwf_pkg::div_stat_t               stat
);
	import tmwf_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  div_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  neg_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    shifted;
	logic                  fits;
	logic [DIVISOR_W:0]    diff;

	assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
	assign fits = shifted >= {1'b0, div_q};
	assign diff = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DIVIDEND_W);
				neg_q <= dividend[DIVIDEND_W-1];
				quo_q <= dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : dividend;
				rem_q <= '0;
				div_q <= divisor;
			end else if (busy_q) begin
				quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
				rem_q <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign quotient = neg_q ? DIVIDEND_W'(-quo_q) : quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire

FILE: src/trimmed_mean_window_filter.sv
// Trimmed mean window filter: sample ring, sequential scan and serial division.
// An accepted sample is written to the ring; the filter then scans the count filled slots
// (WINDOW once the ring is full) and divides their sum, less the highest and lowest once full.
// The ring memory is read one slot per cycle and the divider produces one bit per cycle.
// s_tready is low while an item is in work; a new transaction waits until m_tdata is loaded.
// Reset clears write slot, full flag, state, strobes and counters; ring contents are not cleared.
`default_nettype none
module trimmed_mean_window_filter #(
	parameter int WINDOW = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] sample
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [15:0] filtered
	output logic             m_tuser    // [0] window_full
);
	import tmwf_pkg::*;

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PREP,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                  state_q;
	logic [SAMPLE_W-1:0]     ring_mem [WINDOW];
	logic [SAMPLE_W-1:0]     rd_data_s1;
	logic                    rd_pend_s1;
	logic [SLOT_W-1:0]       slot_q;
	logic                    filled_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        issue_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SAMPLE_W-1:0] hi_q;
	logic signed [SAMPLE_W-1:0] lo_q;
	logic                    first_q;
	logic signed [SUM_W-1:0] dividend_q;
	logic [CNT_W-1:0]        divisor_q;
	logic                    div_start_q;
	logic signed [SUM_W-1:0] quotient;
	div_stat_t               div_stat;
	logic                    accept;
	logic                    out_load;
	logic                    slot_last;
	logic signed [SAMPLE_W-1:0] rd_val;
	logic signed [SUM_W-1:0] rd_ext;
	logic signed [SUM_W-1:0] hi_ext;
	logic signed [SUM_W-1:0] lo_ext;

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_load = (state_q == ST_OUT) && (!m_tvalid || m_tready);
	assign slot_last = (slot_q == SLOT_W'(WINDOW - 1));
	assign rd_val = rd_data_s1;
	assign rd_ext = SUM_W'(rd_val);
	assign hi_ext = SUM_W'(hi_q);
	assign lo_ext = SUM_W'(lo_q);

	always_ff @(posedge clk) begin
		if (accept) begin
			ring_mem[slot_q] <= s_tdata;
		end
		rd_data_s1 <= ring_mem[issue_q[SLOT_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q <= '0;
			filled_q <= 1'b0;
			rd_pend_s1 <= 1'b0;
			div_start_q <= 1'b0;
			m_tvalid <= 1'b0;
			issue_q <= '0;
			count_q <= '0;
		end else begin
			div_start_q <= (state_q == ST_PREP);
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						slot_q <= slot_last ? '0 : slot_q + 1'b1;
						filled_q <= filled_q | slot_last;
						count_q <= (filled_q || slot_last) ? CNT_W'(WINDOW)
							: CNT_W'(slot_q) + 1'b1;
						issue_q <= '0;
						rd_pend_s1 <= 1'b0;
						first_q <= 1'b1;
						sum_q <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue_q < count_q) begin
						issue_q <= issue_q + 1'b1;
						rd_pend_s1 <= 1'b1;
					end else begin
						rd_pend_s1 <= 1'b0;
					end
					if (rd_pend_s1) begin
						sum_q <= sum_q + rd_ext;
						first_q <= 1'b0;
						if (first_q || rd_val > hi_q) begin
							hi_q <= rd_val;
						end
						if (first_q || rd_val < lo_q) begin
							lo_q <= rd_val;
						end
					end
					if (issue_q == count_q && !rd_pend_s1) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					dividend_q <= filled_q ? sum_q - hi_ext - lo_ext : sum_q;
					divisor_q <= filled_q ? CNT_W'(WINDOW - 2) : count_q;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						m_tdata <= quotient[SAMPLE_W-1:0];
						m_tuser <= filled_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	tmwf_div #(
		.DIVIDEND_W(SUM_W),
		.DIVISOR_W (CNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start_q),
		.dividend(dividend_q),
		.divisor (divisor_q),
		.quotient(quotient),
		.stat    (div_stat)
	);

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(slot_q) < WINDOW)
		else $error("write slot left the ring");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !div_stat.busy && !div_stat.done)
		else $error("transaction accepted while the divider works");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q |=> filled_q)
		else $error("window full flag dropped");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> issue_q <= count_q && int'(count_q) <= WINDOW)
		else $error("scan index ran past the filled slots");

endmodule
`default_nettype wire
